>>> rtl/core/spiral_order_matrix_reader_assert.svh
// assertion macros shared by the spiral order matrix reader rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef SPIRAL_ORDER_MATRIX_READER_ASSERT_SVH
`define SPIRAL_ORDER_MATRIX_READER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SORM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SORM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SORM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SORM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/sorm_pkg.sv
// types and constants of the spiral order matrix reader
// no dependencies
`timescale 1ns / 1ps

package sorm_pkg;

  localparam int SORM_MAX_DIM = 32;     // default largest matrix side
  localparam int DATA_W       = 8;      // byte width
  localparam int DIM_REG_W    = 6;      // row_count / col_count register width
  localparam int WALK_W       = 6;      // walker coordinate and bound width
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [DIM_REG_W-1:0] RESET_DIM    = DIM_REG_W'(1);
  localparam logic [DATA_W-1:0]    RESET_OFFSET = DATA_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT   = 2'd0,
    CFG_COL_COUNT   = 2'd1,
    CFG_CHAR_OFFSET = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // walker position, heading and shrinking bounds
  typedef struct packed {
    logic [WALK_W-1:0] row;
    logic [WALK_W-1:0] col;
    dir_t              dir;
    logic [WALK_W-1:0] left;
    logic [WALK_W-1:0] right;
    logic [WALK_W-1:0] top;
    logic [WALK_W-1:0] bottom;
  } walker_t;

endpackage

>>> rtl/core/sorm_if.sv
// valid/ready channel interfaces for command words and result words
// depends on sorm_pkg
`timescale 1ns / 1ps

interface sorm_in_if import sorm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface sorm_out_if import sorm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic              last;
  logic              empty_res;

  modport source (output valid, output data_out, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input data_out, input last, input empty_res,
                  output ready);
endinterface

>>> rtl/core/sorm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sorm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/spiral_order_matrix_reader.sv
// spiral order matrix reader: top level with walker, counters and result register
// depends on sorm_pkg, sorm_if, sorm_ram and spiral_order_matrix_reader_assert.svh
`timescale 1ns / 1ps
`include "spiral_order_matrix_reader_assert.svh"

// usage
// - in_if carries command words: cmd load stores data_in minus char_offset at the
//   next row-major slot, cmd read asks for the next byte in clockwise spiral order
// - out_if carries one result word per read: data_out, last on the final byte of
//   the matrix (the buffer then clears), empty_res when nothing was pending
// - loads produce no result word; loads past row_count * col_count are dropped
// - cfg_we / cfg_index / cfg_wdata write row_count, col_count and char_offset;
//   write them only while no read is outstanding
// - throughput: one command word per cycle, loads and reads mixed freely
// - latency: a read's result is valid the cycle after it is accepted, set by the
//   registered read port of the matrix ram
// - the result register holds while out_if.ready is low and in_if.ready drops
//   then, so nothing moves until the result word is taken
// - reset (rst_n low, synchronous) empties the matrix and restores row_count 1,
//   col_count 1, char_offset 7; ram contents are not cleared, no sweep needed
module spiral_order_matrix_reader import sorm_pkg::*; #(
  parameter int MAX_DIM = SORM_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sorm_in_if.sink               in_if,
  sorm_out_if.source            out_if
);

  localparam int STORE_SIZE = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int CNT_W      = $clog2(STORE_SIZE + 1);
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int AF_W       = WALK_W + DIM_W + 1;   // full walker address

  // configuration registers
  logic [DIM_REG_W-1:0] row_count_r, col_count_r;
  logic [DATA_W-1:0]    char_offset_r;

  // matrix bookkeeping
  logic [CNT_W-1:0] loaded_count_r, loaded_count_nxt;
  logic [CNT_W-1:0] emitted_count_r, emitted_count_nxt;
  walker_t          walk_r, walk_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic last_r, last_nxt;
  logic empty_r, empty_nxt;
  logic zero_r, zero_nxt;      // result reads as zero instead of ram data

  logic [DATA_W-1:0] ram_q;
  logic              ram_we, ram_re;

  // effective dimensions, clamped to 1..MAX_DIM
  logic [DIM_W-1:0]   eff_rows, eff_cols;
  logic [2*DIM_W-1:0] cap;
  walker_t            start_w, cur_w, adv_w;
  logic [AF_W-1:0]    addr_full;
  logic               in_range, pending, done;
  logic               accept, is_read, is_load, can_load;
  logic [CNT_W-1:0]   emit_inc;

  always_comb begin
    if (row_count_r == '0) begin
      eff_rows = DIM_W'(1);
    end else if ({1'b0, row_count_r} > 7'(MAX_DIM)) begin
      eff_rows = DIM_W'(MAX_DIM);
    end else begin
      eff_rows = DIM_W'(row_count_r);
    end
    if (col_count_r == '0) begin
      eff_cols = DIM_W'(1);
    end else if ({1'b0, col_count_r} > 7'(MAX_DIM)) begin
      eff_cols = DIM_W'(MAX_DIM);
    end else begin
      eff_cols = DIM_W'(col_count_r);
    end
  end

  assign cap = eff_rows * eff_cols;

  // walker as it stands at the first read of a matrix
  always_comb begin
    start_w        = '0;
    start_w.dir    = DIR_RIGHT;
    start_w.right  = WALK_W'(eff_cols) - WALK_W'(1);
    start_w.bottom = WALK_W'(eff_rows) - WALK_W'(1);
  end

  assign cur_w = (emitted_count_r == '0) ? start_w : walk_r;

  assign addr_full = AF_W'(cur_w.row) * AF_W'(eff_cols) + AF_W'(cur_w.col);
  // anything below the fill count was written for this matrix
  assign in_range  = addr_full < AF_W'(loaded_count_r);
  assign pending   = emitted_count_r < loaded_count_r;
  assign emit_inc  = emitted_count_r + CNT_W'(1);
  assign done      = emit_inc >= loaded_count_r;

  // one step around the spiral; bounds shrink as each side is finished
  always_comb begin
    adv_w = cur_w;
    unique case (cur_w.dir)
      DIR_RIGHT: begin
        if (cur_w.col == cur_w.right) begin
          adv_w.dir = DIR_DOWN;
          adv_w.top = cur_w.top + WALK_W'(1);
          adv_w.row = cur_w.row + WALK_W'(1);
        end else begin
          adv_w.col = cur_w.col + WALK_W'(1);
        end
      end
      DIR_DOWN: begin
        if (cur_w.row == cur_w.bottom) begin
          adv_w.dir   = DIR_LEFT;
          adv_w.right = cur_w.right - WALK_W'(1);
          adv_w.col   = cur_w.col - WALK_W'(1);
        end else begin
          adv_w.row = cur_w.row + WALK_W'(1);
        end
      end
      DIR_LEFT: begin
        if (cur_w.col == cur_w.left) begin
          adv_w.dir    = DIR_UP;
          adv_w.bottom = cur_w.bottom - WALK_W'(1);
          adv_w.row    = cur_w.row - WALK_W'(1);
        end else begin
          adv_w.col = cur_w.col - WALK_W'(1);
        end
      end
      DIR_UP: begin
        if (cur_w.row == cur_w.top) begin
          adv_w.dir  = DIR_RIGHT;
          adv_w.left = cur_w.left + WALK_W'(1);
          adv_w.col  = cur_w.col + WALK_W'(1);
        end else begin
          adv_w.row = cur_w.row - WALK_W'(1);
        end
      end
      default: begin
        adv_w = cur_w;
      end
    endcase
  end

  // handshake: the result register is the only buffer, so take a word only
  // when it is empty or being drained this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign is_read     = accept && (in_if.cmd == CMD_READ);
  assign is_load     = accept && (in_if.cmd == CMD_LOAD);
  assign can_load    = loaded_count_r < cap;

  assign ram_we = is_load && can_load;
  assign ram_re = is_read && pending && in_range;

  always_comb begin
    loaded_count_nxt  = loaded_count_r;
    emitted_count_nxt = emitted_count_r;
    walk_nxt          = walk_r;
    out_valid_nxt     = out_valid_r && !out_if.ready;
    last_nxt          = last_r;
    empty_nxt         = empty_r;
    zero_nxt          = zero_r;
    if (ram_we) begin
      loaded_count_nxt = loaded_count_r + CNT_W'(1);
    end
    if (is_read) begin
      out_valid_nxt = 1'b1;
      if (!pending) begin
        last_nxt  = 1'b0;
        empty_nxt = 1'b1;
        zero_nxt  = 1'b1;
      end else begin
        empty_nxt = 1'b0;
        zero_nxt  = !in_range;
        last_nxt  = done;
        if (done) begin
          // matrix finished: clear for the next one
          loaded_count_nxt  = '0;
          emitted_count_nxt = '0;
          walk_nxt          = start_w;
        end else begin
          emitted_count_nxt = emit_inc;
          walk_nxt          = adv_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= RESET_DIM;
      col_count_r     <= RESET_DIM;
      char_offset_r   <= RESET_OFFSET;
      loaded_count_r  <= '0;
      emitted_count_r <= '0;
      walk_r          <= '0;
      out_valid_r     <= 1'b0;
      last_r          <= 1'b0;
      empty_r         <= 1'b0;
      zero_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW_COUNT:   row_count_r   <= cfg_wdata[DIM_REG_W-1:0];
          CFG_COL_COUNT:   col_count_r   <= cfg_wdata[DIM_REG_W-1:0];
          CFG_CHAR_OFFSET: char_offset_r <= cfg_wdata[DATA_W-1:0];
          default: begin
          end
        endcase
      end
      loaded_count_r  <= loaded_count_nxt;
      emitted_count_r <= emitted_count_nxt;
      walk_r          <= walk_nxt;
      out_valid_r     <= out_valid_nxt;
      last_r          <= last_nxt;
      empty_r         <= empty_nxt;
      zero_r          <= zero_nxt;
    end
  end

  sorm_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (loaded_count_r[ADDR_W-1:0]),
    .wdata (in_if.data_in - char_offset_r),
    .re    (ram_re),
    .raddr (addr_full[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  assign out_if.valid     = out_valid_r;
  assign out_if.data_out  = zero_r ? '0 : ram_q;
  assign out_if.last      = last_r;
  assign out_if.empty_res = empty_r;

  // checks
  `SORM_ASSERT_NOW(a_emit_le_load, clk, rst_n, 1'b1, emitted_count_r <= loaded_count_r,
    "more bytes emitted than loaded")
  `SORM_ASSERT_NEXT(a_last_clears, clk, rst_n, is_read && pending && done,
    loaded_count_r == '0 && emitted_count_r == '0, "matrix not cleared after last byte")
  `SORM_ASSERT_NEXT(a_read_gives_word, clk, rst_n, is_read, out_valid_r,
    "accepted read produced no result word")
  `SORM_ASSERT_NOW(a_empty_is_plain, clk, rst_n, out_valid_r && empty_r,
    !last_r && out_if.data_out == '0, "empty result carries data or last")
  `SORM_ASSERT_NEXT(a_load_no_word, clk, rst_n, is_load && !out_valid_r, !out_valid_r,
    "load produced a result word")

endmodule

>>> bench/spiral_order_matrix_reader_test.sv
// self-checking bench for the spiral order matrix reader: load and read command words
// go in, spiral-order result words come out and are matched against a local predictor
// depends on sorm_pkg, sorm_if and the spiral_order_matrix_reader rtl
`timescale 1ns / 1ps

module spiral_order_matrix_reader_test;
  import sorm_pkg::*;

  localparam int STORE_SIZE     = SORM_MAX_DIM * SORM_MAX_DIM;
  localparam int RANDOM_WORDS   = 700;   // rough number of words over the random phases
  localparam int TALL_COLS      = 4;     // columns of the tall full matrix phase
  localparam int SETTLE_CYCLES  = 3;     // margin for the pipe to empty after the last result word
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  // index with no register behind it, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              last;
    logic              empty_res;
  } spiral_result_t;

  // predicts the spiral walk and holds the result words still owed by the block
  class spiral_walk_predictor;
    logic [DATA_W-1:0]    store [STORE_SIZE];
    logic [DIM_REG_W-1:0] rows_reg;
    logic [DIM_REG_W-1:0] cols_reg;
    logic [DATA_W-1:0]    offset_reg;
    int unsigned          loaded;
    int unsigned          emitted;
    logic [WALK_W-1:0]    w_row, w_col;
    logic [WALK_W-1:0]    b_left, b_right, b_top, b_bottom;
    dir_t                 w_dir;
    spiral_result_t       owed_words[$];
    int                   failures;

    function new();
      rows_reg   = RESET_DIM;
      cols_reg   = RESET_DIM;
      offset_reg = RESET_OFFSET;
      failures   = 0;
      clear_matrix();
    endfunction

    function int unsigned eff_dim(logic [DIM_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SORM_MAX_DIM) return SORM_MAX_DIM;
      return v;
    endfunction

    function void restart_walk();
      w_row    = '0;
      w_col    = '0;
      w_dir    = DIR_RIGHT;
      b_left   = '0;
      b_top    = '0;
      b_right  = WALK_W'(eff_dim(cols_reg) - 1);
      b_bottom = WALK_W'(eff_dim(rows_reg) - 1);
    endfunction

    function void clear_matrix();
      loaded  = 0;
      emitted = 0;
      restart_walk();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ROW_COUNT:   rows_reg   = value[DIM_REG_W-1:0];
        CFG_COL_COUNT:   cols_reg   = value[DIM_REG_W-1:0];
        CFG_CHAR_OFFSET: offset_reg = value;
        default: ;
      endcase
    endfunction

    function void note_word(cmd_t cmd, logic [DATA_W-1:0] data);
      int unsigned    cols;
      int unsigned    cap;
      int unsigned    addr;
      spiral_result_t res;
      cols = eff_dim(cols_reg);
      cap  = eff_dim(rows_reg) * cols;
      if (cmd == CMD_LOAD) begin
        if (loaded < cap && loaded < STORE_SIZE) begin
          store[loaded] = data - offset_reg;
          loaded++;
        end
        return;
      end
      res = '0;
      if (emitted >= loaded) begin
        res.empty_res = 1'b1;
        owed_words.push_back(res);
        return;
      end
      if (emitted == 0) restart_walk();
      addr = w_row * cols + w_col;
      if (addr < loaded && addr < STORE_SIZE) res.data_out = store[addr];
      emitted++;
      if (emitted >= loaded) begin
        res.last = 1'b1;
        clear_matrix();
      end else begin
        case (w_dir)
          DIR_RIGHT: if (w_col == b_right) begin
            w_dir = DIR_DOWN;
            b_top = b_top + 1'b1;
            w_row = w_row + 1'b1;
          end else begin
            w_col = w_col + 1'b1;
          end
          DIR_DOWN: if (w_row == b_bottom) begin
            w_dir   = DIR_LEFT;
            b_right = b_right - 1'b1;
            w_col   = w_col - 1'b1;
          end else begin
            w_row = w_row + 1'b1;
          end
          DIR_LEFT: if (w_col == b_left) begin
            w_dir    = DIR_UP;
            b_bottom = b_bottom - 1'b1;
            w_row    = w_row - 1'b1;
          end else begin
            w_col = w_col - 1'b1;
          end
          default: if (w_row == b_top) begin
            w_dir  = DIR_RIGHT;
            b_left = b_left + 1'b1;
            w_col  = w_col + 1'b1;
          end else begin
            w_row = w_row - 1'b1;
          end
        endcase
      end
      owed_words.push_back(res);
    endfunction

    function void check_result(spiral_result_t got);
      spiral_result_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: result word with none owed, actual %02h last %b empty %b",
                 $time, got.data_out, got.last, got.empty_res);
        failures++;
        return;
      end
      want = owed_words.pop_front();
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out expected %02h actual %02h", $time, want.data_out,
                 got.data_out);
        failures++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        failures++;
      end
      if (got.empty_res !== want.empty_res) begin
        $display("%0t: empty_res expected %b actual %b", $time, want.empty_res,
                 got.empty_res);
        failures++;
      end
    endfunction

    function int owed_count();
      return owed_words.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sorm_in_if  in_ch ();
  sorm_out_if out_ch ();

  spiral_order_matrix_reader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  spiral_walk_predictor walk_model;
  logic in_idle_on;    // random gaps on the command side
  logic out_idle_on;   // random stalls on the result side
  int   words_sent;
  int   idle_cycles;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sample every handshake at the rising edge; results first so a word
  // accepted on this edge only queues behind older owed words
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) walk_model.write_reg(cfg_index, cfg_wdata);
      if (out_ch.valid && out_ch.ready)
        walk_model.check_result('{out_ch.data_out, out_ch.last, out_ch.empty_res});
      if (in_ch.valid && in_ch.ready)
        walk_model.note_word(cmd_t'(in_ch.cmd), in_ch.data_in);
      // watchdog: any handshake clears the count
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  // drive one command word and hold it until the block takes it; valid stays
  // high on return so the next word can follow back to back
  task automatic send_word(input cmd_t cmd, input logic [DATA_W-1:0] data);
    if (in_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.cmd     = cmd;
    in_ch.data_in = data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // stop sending, wait for every owed result word, then let the pipe empty
  task automatic wait_for_results();
    in_ch.valid = 1'b0;
    while (walk_model.owed_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // dimension value: mostly small, sometimes zero, the maximum, out of range,
  // or with junk in the bits above the register width
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(SORM_MAX_DIM);
      2: return {2'($urandom), 6'($urandom_range(SORM_MAX_DIM + 1, 63))};
      3: return {2'($urandom_range(1, 3)), 6'($urandom_range(1, 6))};
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // load then read a whole matrix, sometimes partial, overfilled or interleaved;
  // the rest is random noise or a short burst followed by a full drain
  task automatic run_sequence(input int unsigned cap, input bit full_size);
    int unsigned n;
    int unsigned loads_left;
    int unsigned reads_left;
    int          kind;
    bit          interleave;
    kind = full_size ? 0 : $urandom_range(0, 9);
    if (kind <= 6) begin
      if (full_size) n = cap;
      else if (cap <= 48) n = ($urandom_range(0, 3) != 0) ? cap : $urandom_range(1, cap);
      else n = $urandom_range(1, 48);
      loads_left = n;
      reads_left = n;
      // loads past a full matrix are dropped
      if (n == cap && (full_size || $urandom_range(0, 3) == 0))
        loads_left += $urandom_range(1, 3);
      // reads with nothing pending give empty words
      if ($urandom_range(0, 3) == 0) reads_left += $urandom_range(1, 2);
      interleave = !full_size && $urandom_range(0, 2) == 0;
      while (loads_left != 0 || reads_left != 0) begin
        if (loads_left != 0 && (reads_left == 0 || !interleave || $urandom_range(0, 1))) begin
          send_word(CMD_LOAD, DATA_W'($urandom));
          loads_left--;
        end else begin
          send_word(CMD_READ, DATA_W'($urandom));
          reads_left--;
        end
      end
    end else if (kind <= 8) begin
      repeat ($urandom_range(4, 20)) send_word(cmd_t'($urandom_range(0, 1)), DATA_W'($urandom));
    end else begin
      // hold the sender off until every owed word is back
      repeat ($urandom_range(1, 4)) send_word(CMD_LOAD, DATA_W'($urandom));
      send_word(CMD_READ, DATA_W'($urandom));
      wait_for_results();
    end
  endtask

  initial begin
    int                    phase;
    int                    random_words;
    int                    phase_start;
    int unsigned           cap;
    bit                    full_size;
    logic [CFG_DATA_W-1:0] rows_val;
    logic [CFG_DATA_W-1:0] cols_val;

    walk_model    = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ROW_COUNT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_LOAD;
    in_ch.data_in = '0;
    in_idle_on    = 1'b0;
    out_idle_on   = 1'b0;
    words_sent    = 0;
    idle_cycles   = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset values: 1 by 1 matrix, offset 7 wraps the zero byte
    send_word(CMD_LOAD, 8'h00);
    send_word(CMD_READ, DATA_W'($urandom));
    send_word(CMD_READ, DATA_W'($urandom));
    wait_for_results();

    // 2 by 3 full matrix with byte extremes, one load too many, one empty read
    write_reg(CFG_ROW_COUNT, 8'd2);
    write_reg(CFG_COL_COUNT, 8'd3);
    write_reg(CFG_CHAR_OFFSET, 8'h00);
    send_word(CMD_LOAD, 8'hFF);
    send_word(CMD_LOAD, 8'h80);
    send_word(CMD_LOAD, 8'h7F);
    send_word(CMD_LOAD, 8'h01);
    send_word(CMD_LOAD, 8'hAA);
    send_word(CMD_LOAD, 8'h55);
    send_word(CMD_LOAD, 8'h12);
    repeat (7) send_word(CMD_READ, DATA_W'($urandom));
    wait_for_results();

    // 3 by 3 partly loaded: the walk turns down into unloaded slots that read 0
    write_reg(CFG_ROW_COUNT, 8'd3);
    write_reg(CFG_COL_COUNT, 8'd3);
    write_reg(CFG_CHAR_OFFSET, 8'hFF);
    send_word(CMD_LOAD, 8'h00);
    send_word(CMD_LOAD, 8'hFF);
    send_word(CMD_LOAD, 8'h10);
    send_word(CMD_LOAD, 8'h20);
    repeat (4) send_word(CMD_READ, DATA_W'($urandom));

    // random phases, each with its own register setting; a matrix left part
    // loaded by one phase is finished under the next phase's dimensions
    phase        = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      wait_for_results();
      // last part of the run goes without idling on either side
      in_idle_on  = random_words < RANDOM_WORDS * 9 / 10 && $urandom_range(0, 3) != 0;
      out_idle_on = random_words < RANDOM_WORDS * 9 / 10 && $urandom_range(0, 3) != 0;
      // one tall matrix filled completely, reaching the last row
      full_size   = phase == 2;
      rows_val    = full_size ? CFG_DATA_W'(SORM_MAX_DIM) : pick_dim();
      cols_val    = full_size ? CFG_DATA_W'(TALL_COLS) : pick_dim();
      write_reg(CFG_ROW_COUNT, rows_val);
      write_reg(CFG_COL_COUNT, cols_val);
      write_reg(CFG_CHAR_OFFSET, pick_offset());
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
      cap = walk_model.eff_dim(rows_val[DIM_REG_W-1:0]) *
            walk_model.eff_dim(cols_val[DIM_REG_W-1:0]);
      phase_start = words_sent;
      repeat (full_size ? 1 : $urandom_range(1, 3)) run_sequence(cap, full_size);
      random_words += words_sent - phase_start;
      phase++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES + 8) @(posedge clk);
    if (walk_model.owed_count() != 0) begin
      $display("%0t: %0d result words never arrived", $time, walk_model.owed_count());
      walk_model.failures++;
    end
    if (walk_model.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
